// ----- rtl/pba_pkg.sv -----
package pba_pkg;

  // Fixed geometry of the heap
  localparam int AddrBits    = 16;
  localparam int FirstBucket = 3;
  localparam int NumBuckets  = 16;
  localparam int WordBytes   = 4;
  localparam int BktW        = $clog2(NumBuckets);
  localparam int HdrDepth    = (1 << AddrBits) / WordBytes;
  localparam int HdrAw       = $clog2(HdrDepth);
  localparam int WordSh      = $clog2(WordBytes);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [AddrBits:0]   len_t;
  typedef logic [BktW-1:0]     bkt_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_DONATE  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NO_MEMORY = 2'd3;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  // Block size of a bucket including its header word
  function automatic len_t piece_len(input bkt_t b);
    piece_len = (len_t'(1) << b) + len_t'(WordBytes);
  endfunction

endpackage

// ----- rtl/pba_if.sv -----
interface pba_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        size;
  logic [15:0]        address;
  modport source (output valid, action, size, address, input ready);
  modport sink (input valid, action, size, address, output ready);
endinterface

interface pba_res_if;
  logic               valid;
  logic               ready;
  logic [15:0]        address_res;
  logic [1:0]         status;
  modport source (output valid, address_res, status, input ready);
  modport sink (input valid, address_res, status, output ready);
endinterface

// ----- rtl/pba_ram.sv -----
module pba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/power_of_two_bucket_allocator.sv -----
// Channel  | Dir | Transfer when   | Payload
// req      | in  | valid && ready  | action, size, address
// res      | out | valid && ready  | address_res, status
// cfg      | in  | cfg_we          | cfg_index, cfg_data
//
// One item at a time; req.ready is high only while the sequencer is idle.
// An allocate may split the old bump region into the free lists (one bucket a
// cycle over the single header RAM write port). An ignored donate and a null
// release go straight to finish.
// Reset (rst, synchronous) empties every list and reloads the bump region.
// A waiting result does not block the next request; the next result holds in
// finish until the output register is free.
module power_of_two_bucket_allocator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  pba_req_if.sink            req,
  pba_res_if.source          res
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP_WB, S_SCR_WB, S_DON_STEP, S_CARVE, S_REL_WB, S_FINISH
  } state_t;

  state_t                 state;
  pba_pkg::addr_t         heap_base;
  pba_pkg::addr_t         heap_limit;
  pba_pkg::addr_t         heads [pba_pkg::NumBuckets];
  pba_pkg::len_t          bp;
  pba_pkg::len_t          rem;
  logic [1:0]             act;
  pba_pkg::addr_t         sz;
  pba_pkg::addr_t         ad;
  pba_pkg::bkt_t          bsel;
  pba_pkg::bkt_t          csel;
  pba_pkg::addr_t         head;
  pba_pkg::len_t          need;
  pba_pkg::len_t          dp;
  pba_pkg::len_t          dn;
  pba_pkg::bkt_t          dbk;
  logic                   don_ret;
  pba_pkg::addr_t         res_addr;
  logic [1:0]             res_stat;

  // Combinational search and RAM port signals
  pba_pkg::bkt_t          bfit;
  logic                   bfound;
  pba_pkg::bkt_t          cfit;
  logic                   cfound;
  pba_pkg::len_t          bneed;
  pba_pkg::addr_t         rel_blk;
  pba_pkg::len_t          dal_p;
  pba_pkg::len_t          dal_n;
  pba_pkg::len_t          adj;
  pba_pkg::len_t          dpiece;
  logic [pba_pkg::AddrBits+1:0] region_end;
  logic                   ram_we;
  logic [pba_pkg::HdrAw-1:0] ram_waddr;
  pba_pkg::addr_t         ram_wdata;
  logic [pba_pkg::HdrAw-1:0] ram_raddr;
  pba_pkg::addr_t         ram_rdata;
  pba_pkg::len_t          reload_p;
  pba_pkg::addr_t         cfg_base;
  pba_pkg::addr_t         cfg_limit;

  // Find smallest bucket that holds the request
  always_comb begin
    bfit = pba_pkg::bkt_t'(pba_pkg::FirstBucket);
    bfound = 1'b0;
    for (int c = pba_pkg::NumBuckets - 1; c >= pba_pkg::FirstBucket; c--) begin
      if ((pba_pkg::len_t'(1) << c) >= pba_pkg::len_t'(sz)) begin
        bfit = pba_pkg::bkt_t'(c);
        bfound = 1'b1;
      end
    end
    bneed = pba_pkg::piece_len(bfit);
  end

  // Find smallest non-empty bucket big enough to become the bump region
  always_comb begin
    cfit = pba_pkg::bkt_t'(pba_pkg::FirstBucket);
    cfound = 1'b0;
    for (int c = pba_pkg::NumBuckets - 1; c >= pba_pkg::FirstBucket; c--) begin
      if (heads[c] != '0 && pba_pkg::piece_len(pba_pkg::bkt_t'(c)) >= bneed) begin
        cfit = pba_pkg::bkt_t'(c);
        cfound = 1'b1;
      end
    end
  end

  // Align a donated region and clip it to the address space
  always_comb begin
    adj = pba_pkg::len_t'(pba_pkg::WordBytes)
        - pba_pkg::len_t'(ad[pba_pkg::WordSh-1:0]);
    if (ad[pba_pkg::WordSh-1:0] != '0) begin
      dal_p = pba_pkg::len_t'(ad) + adj;
      dal_n = (pba_pkg::len_t'(sz) > adj) ? pba_pkg::len_t'(sz) - adj : '0;
    end else begin
      dal_p = pba_pkg::len_t'(ad);
      dal_n = pba_pkg::len_t'(sz);
    end
    if (!dal_p[pba_pkg::AddrBits] &&
        dal_n > (pba_pkg::len_t'(1) << pba_pkg::AddrBits) - dal_p) begin
      dal_n = (pba_pkg::len_t'(1) << pba_pkg::AddrBits) - dal_p;
    end
  end

  assign rel_blk = (ad - pba_pkg::addr_t'(pba_pkg::WordBytes))
                 & ~pba_pkg::addr_t'(pba_pkg::WordBytes - 1);
  assign dpiece = pba_pkg::piece_len(dbk);
  assign region_end = (pba_pkg::AddrBits+2)'(bp) + (pba_pkg::AddrBits+2)'(rem);

  // Read address, used in decode only
  always_comb begin
    ram_raddr = rel_blk[pba_pkg::AddrBits-1:pba_pkg::WordSh];
    if (act == pba_pkg::ACT_ALLOC) begin
      if (heads[bfit] != '0) begin
        ram_raddr = heads[bfit][pba_pkg::AddrBits-1:pba_pkg::WordSh];
      end else begin
        ram_raddr = heads[cfit][pba_pkg::AddrBits-1:pba_pkg::WordSh];
      end
    end
  end

  // Header write port
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = head[pba_pkg::AddrBits-1:pba_pkg::WordSh];
    ram_wdata = pba_pkg::addr_t'(bsel);
    case (state)
      S_POP_WB: ram_we = 1'b1;
      S_CARVE: begin
        ram_we = 1'b1;
        ram_waddr = bp[pba_pkg::AddrBits-1:pba_pkg::WordSh];
      end
      S_DON_STEP: begin
        ram_we = (dn >= dpiece);
        ram_waddr = dp[pba_pkg::AddrBits-1:pba_pkg::WordSh];
        ram_wdata = heads[dbk];
      end
      S_REL_WB: begin
        ram_we = (ram_rdata >= pba_pkg::addr_t'(pba_pkg::FirstBucket)) &&
                 (ram_rdata < pba_pkg::addr_t'(pba_pkg::NumBuckets));
        ram_wdata = heads[ram_rdata[pba_pkg::BktW-1:0]];
      end
      default: ram_we = 1'b0;
    endcase
  end

  pba_ram #(
    .WIDTH (pba_pkg::AddrBits),
    .DEPTH (pba_pkg::HdrDepth)
  ) u_hdr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Bump region reload from configuration
  always_comb begin
    cfg_base = heap_base;
    cfg_limit = heap_limit;
    if (cfg_we && cfg_index == pba_pkg::CFG_HEAP_BASE) cfg_base = cfg_data;
    if (cfg_we && cfg_index == pba_pkg::CFG_HEAP_LIMIT) cfg_limit = cfg_data;
    reload_p = (pba_pkg::len_t'(cfg_base) + pba_pkg::len_t'(pba_pkg::WordBytes - 1))
             & ~pba_pkg::len_t'(pba_pkg::WordBytes - 1);
  end

  assign req.ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      heap_base <= pba_pkg::addr_t'(4);
      heap_limit <= '1;
      bp <= pba_pkg::len_t'(4);
      rem <= pba_pkg::len_t'(16'hFFFF) - pba_pkg::len_t'(4);
      for (int i = 0; i < pba_pkg::NumBuckets; i++) heads[i] <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_FINISH) res.valid <= 1'b0;
      if (cfg_we) begin
        heap_base <= cfg_base;
        heap_limit <= cfg_limit;
        bp <= reload_p;
        rem <= (pba_pkg::len_t'(cfg_limit) > reload_p)
             ? pba_pkg::len_t'(cfg_limit) - reload_p : '0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            act <= req.action;
            sz <= req.size;
            ad <= req.address;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_addr <= '0;
          res_stat <= pba_pkg::ST_OK;
          state <= S_FINISH;
          case (act)
            pba_pkg::ACT_ALLOC: begin
              bsel <= bfit;
              need <= bneed;
              if (sz == '0) begin
                res_stat <= pba_pkg::ST_ZERO_SIZE;
              end else if (!bfound) begin
                res_stat <= pba_pkg::ST_TOO_LARGE;
              end else if (heads[bfit] != '0) begin
                head <= heads[bfit];
                state <= S_POP_WB;
              end else if (bneed > rem) begin
                if (!cfound) begin
                  res_stat <= pba_pkg::ST_NO_MEMORY;
                end else begin
                  head <= heads[cfit];
                  csel <= cfit;
                  state <= S_SCR_WB;
                end
              end else begin
                state <= S_CARVE;
              end
            end
            pba_pkg::ACT_RELEASE: begin
              if (ad >= pba_pkg::addr_t'(pba_pkg::WordBytes)) begin
                head <= rel_blk;
                state <= S_REL_WB;
              end
            end
            pba_pkg::ACT_DONATE: begin
              dp <= dal_p;
              dn <= dal_n;
              dbk <= pba_pkg::bkt_t'(pba_pkg::NumBuckets - 1);
              don_ret <= 1'b0;
              if (ad != '0 && sz != '0 && !dal_p[pba_pkg::AddrBits]) begin
                state <= S_DON_STEP;
              end
            end
            default: state <= S_FINISH;
          endcase
        end
        S_POP_WB: begin
          heads[bsel] <= ram_rdata;
          res_addr <= head + pba_pkg::addr_t'(pba_pkg::WordBytes);
          state <= S_FINISH;
        end
        S_SCR_WB: begin
          heads[csel] <= ram_rdata;
          if (region_end != (pba_pkg::AddrBits+2)'(head)) begin
            // Drop a remainder that lies past the address space, clip the rest
            dp <= bp;
            dn <= bp[pba_pkg::AddrBits] ? '0
                : ((rem > (pba_pkg::len_t'(1) << pba_pkg::AddrBits) - bp)
                   ? (pba_pkg::len_t'(1) << pba_pkg::AddrBits) - bp : rem);
            dbk <= pba_pkg::bkt_t'(pba_pkg::NumBuckets - 1);
            don_ret <= 1'b1;
            bp <= pba_pkg::len_t'(head);
            rem <= pba_pkg::piece_len(csel);
            state <= S_DON_STEP;
          end else begin
            rem <= rem + pba_pkg::piece_len(csel);
            state <= S_CARVE;
          end
        end
        S_DON_STEP: begin
          if (dn >= dpiece) begin
            heads[dbk] <= dp[pba_pkg::AddrBits-1:0];
            dp <= dp + dpiece;
            dn <= dn - dpiece;
          end
          if (dbk == pba_pkg::bkt_t'(pba_pkg::FirstBucket)) begin
            state <= don_ret ? S_CARVE : S_FINISH;
          end else begin
            dbk <= dbk - 1'b1;
          end
        end
        S_CARVE: begin
          bp <= bp + need;
          rem <= rem - need;
          res_addr <= bp[pba_pkg::AddrBits-1:0] + pba_pkg::addr_t'(pba_pkg::WordBytes);
          state <= S_FINISH;
        end
        S_REL_WB: begin
          if (ram_we) heads[ram_rdata[pba_pkg::BktW-1:0]] <= head;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            res.address_res <= res_addr;
            res.status <= res_stat;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Bump region stays word aligned and within the pointer range
  a_bp_aligned: assert property (@(posedge clk) disable iff (rst)
    bp[pba_pkg::WordSh-1:0] == '0) else $error("bump pointer unaligned");
  a_region_in_space: assert property (@(posedge clk) disable iff (rst)
    region_end < ((pba_pkg::AddrBits+2)'(1) << (pba_pkg::AddrBits+1)))
    else $error("bump region beyond pointer range");
  a_res_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == S_FINISH))
    else $error("result without finish");
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) && res.status != pba_pkg::ST_OK |-> res.address_res == '0)
    else $error("address on failed request");

endmodule
